FILE: rtl/json_string_unescape_assert.svh
// Assertion macros shared by the JSON string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define JSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/jsu_pkg.sv
// Types, codes and decode helpers for the JSON string unescaper.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
    localparam logic [2:0] ERR_END_ESC   = 3'd3;
    localparam logic [2:0] ERR_END_HEX   = 3'd4;
    localparam logic [2:0] ERR_BARE_QUOT = 3'd5;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Digits held before the last one of a u-escape
    localparam logic [1:0] HEX_LAST = 2'd3;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_ESC    = 5'b00010,
        MODE_HEX    = 5'b00100,
        MODE_DONE   = 5'b01000,
        MODE_ERR    = 5'b10000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_cnt;
        logic [11:0] accum;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{mode: MODE_NORMAL, hex_cnt: 2'd0, accum: 12'd0};

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
        logic       start_new;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
    } t_result;

    typedef struct packed {
        t_parse_state  next;
        logic [1:0]    count;
        t_result [2:0] res;
    } t_decode;

    // Value of a hex digit of either case, with a valid flag in the top bit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Character of a single-letter escape, with a valid flag in the top bit
    function automatic logic [8:0] esc_map(input logic [7:0] b);
        logic [8:0] m;
        case (b)
            CH_QUOTE: m = {1'b1, CH_QUOTE};
            CH_BSL:   m = {1'b1, CH_BSL};
            CH_SLASH: m = {1'b1, CH_SLASH};
            CH_B:     m = {1'b1, CH_BS};
            CH_F:     m = {1'b1, CH_FF};
            CH_N:     m = {1'b1, CH_LF};
            CH_R:     m = {1'b1, CH_CR};
            CH_T:     m = {1'b1, CH_TAB};
            default:  m = 9'd0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/jsu_if.sv
// Valid/ready channel interfaces for the unescaper's input and result streams.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;
    logic       start_new;

    modport source(output valid, output in_byte, output text_end, output start_new,
                   input ready);
    modport sink(input valid, input in_byte, input text_end, input start_new,
                 output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       run_last;

    modport source(output valid, output out_byte, output kind, output error_code,
                   output run_last, input ready);
    modport sink(input valid, input out_byte, input kind, input error_code,
                 input run_last, output ready);
endinterface

FILE: rtl/jsu_decode.sv
// Parser step: next state and up to three results for one registered item.
module jsu_decode
    import jsu_pkg::*;
(
    input  t_parse_state i_state,
    input  logic         i_strict,
    input  t_item        i_item,
    output t_decode      o_dec
);

    t_parse_state w_cur;
    logic [4:0]   w_hex;
    logic [8:0]   w_esc;
    logic [15:0]  w_cp;

    assign w_cur = i_item.start_new ? PARSE_RESET : i_state;
    assign w_hex = hex_value(i_item.in_byte);
    assign w_esc = esc_map(i_item.in_byte);
    assign w_cp  = {w_cur.accum, w_hex[3:0]};

    // Walk one item through the parser
    always_comb begin
        o_dec.next  = w_cur;
        o_dec.count = 2'd0;
        o_dec.res   = '0;
        if (i_item.text_end) begin
            case (w_cur.mode)
                MODE_NORMAL: begin
                    o_dec.next.mode     = MODE_DONE;
                    o_dec.count         = 2'd1;
                    o_dec.res[0].kind   = KIND_CLOSE;
                end
                MODE_ESC: begin
                    o_dec.next.mode     = MODE_ERR;
                    o_dec.count         = 2'd1;
                    o_dec.res[0].kind   = KIND_ERROR;
                    o_dec.res[0].code   = ERR_END_ESC;
                end
                MODE_HEX: begin
                    o_dec.next.mode     = MODE_ERR;
                    o_dec.count         = 2'd1;
                    o_dec.res[0].kind   = KIND_ERROR;
                    o_dec.res[0].code   = ERR_END_HEX;
                end
                default: begin
                end
            endcase
        end else begin
            case (w_cur.mode)
                MODE_NORMAL: begin
                    if (i_item.in_byte == CH_BSL) begin
                        o_dec.next.mode = MODE_ESC;
                    end else if (i_item.in_byte == CH_QUOTE) begin
                        o_dec.count = 2'd1;
                        if (i_strict) begin
                            o_dec.next.mode   = MODE_ERR;
                            o_dec.res[0].kind = KIND_ERROR;
                            o_dec.res[0].code = ERR_BARE_QUOT;
                        end else begin
                            o_dec.next.mode   = MODE_DONE;
                            o_dec.res[0].kind = KIND_CLOSE;
                        end
                    end else begin
                        o_dec.count        = 2'd1;
                        o_dec.res[0].data  = i_item.in_byte;
                        o_dec.res[0].kind  = KIND_DATA;
                    end
                end
                MODE_ESC: begin
                    if (i_item.in_byte == CH_U) begin
                        o_dec.next.mode    = MODE_HEX;
                        o_dec.next.hex_cnt = 2'd0;
                        o_dec.next.accum   = 12'd0;
                    end else if (w_esc[8]) begin
                        o_dec.next.mode    = MODE_NORMAL;
                        o_dec.count        = 2'd1;
                        o_dec.res[0].data  = w_esc[7:0];
                        o_dec.res[0].kind  = KIND_DATA;
                    end else begin
                        o_dec.next.mode    = MODE_ERR;
                        o_dec.count        = 2'd1;
                        o_dec.res[0].kind  = KIND_ERROR;
                        o_dec.res[0].code  = ERR_BAD_ESC;
                    end
                end
                MODE_HEX: begin
                    if (!w_hex[4]) begin
                        o_dec.next.mode    = MODE_ERR;
                        o_dec.count        = 2'd1;
                        o_dec.res[0].kind  = KIND_ERROR;
                        o_dec.res[0].code  = ERR_BAD_HEX;
                    end else if (w_cur.hex_cnt == HEX_LAST) begin
                        // Encode the code point as UTF-8
                        o_dec.next = PARSE_RESET;
                        if (w_cp[15:7] == 9'd0) begin
                            o_dec.count       = 2'd1;
                            o_dec.res[0].data = {1'b0, w_cp[6:0]};
                        end else if (w_cp[15:11] == 5'd0) begin
                            o_dec.count       = 2'd2;
                            o_dec.res[0].data = {3'b110, w_cp[10:6]};
                            o_dec.res[1].data = {2'b10, w_cp[5:0]};
                        end else begin
                            o_dec.count       = 2'd3;
                            o_dec.res[0].data = {4'b1110, w_cp[15:12]};
                            o_dec.res[1].data = {2'b10, w_cp[11:6]};
                            o_dec.res[2].data = {2'b10, w_cp[5:0]};
                        end
                    end else begin
                        o_dec.next.accum   = {w_cur.accum[7:0], w_hex[3:0]};
                        o_dec.next.hex_cnt = w_cur.hex_cnt + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/json_string_unescape.sv
// Data path: an accepted item is held in the input register, and the parser step
// loads its results from there into the result buffer that drives the result port.
// Throughput: one item per cycle while each gives at most one result and results
// are taken; an item that gives more holds the result buffer until its last is taken.
// Reset (synchronous, active low): parser returns to normal mode, strict_quote
// clears to 0, both stages empty.
`include "json_string_unescape_assert.svh"

module json_string_unescape
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    jsu_in_if.sink      i_in,
    jsu_out_if.source   o_res
);

    logic          r_strict;
    logic          r_in_valid, n_in_valid;
    t_item         r_in, n_in;
    t_parse_state  r_state, n_state;
    t_result [2:0] r_res, n_res;
    logic [1:0]    r_left, n_left;

    t_decode       w_dec;
    logic          w_out_take;
    logic          w_buf_free;
    logic          w_move;

    // Parser step on the registered item
    jsu_decode u_decode (
        .i_state  (r_state),
        .i_strict (r_strict),
        .i_item   (r_in),
        .o_dec    (w_dec)
    );

    assign w_out_take = o_res.valid && o_res.ready;
    assign w_buf_free = (r_left == 2'd0) || (r_left == 2'd1 && o_res.ready);
    assign w_move     = r_in_valid && (w_dec.count == 2'd0 || w_buf_free);

    assign i_in.ready = !r_in_valid || w_move;

    // Drive the result port from the head of the buffer
    assign o_res.valid      = (r_left != 2'd0);
    assign o_res.out_byte   = r_res[0].data;
    assign o_res.kind       = r_res[0].kind;
    assign o_res.error_code = r_res[0].code;
    assign o_res.run_last   = (r_left == 2'd1);

    // Advance the input stage
    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (i_in.valid && i_in.ready) begin
            n_in_valid     = 1'b1;
            n_in.in_byte   = i_in.in_byte;
            n_in.text_end  = i_in.text_end;
            n_in.start_new = i_in.start_new;
        end else if (w_move) begin
            n_in_valid = 1'b0;
        end
    end

    // Shift out taken results, load a new run
    always_comb begin
        n_state = w_move ? w_dec.next : r_state;
        n_res   = r_res;
        n_left  = r_left;
        if (w_out_take) begin
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
            n_left   = r_left - 2'd1;
        end
        if (w_move && w_dec.count != 2'd0) begin
            n_res  = w_dec.res;
            n_left = w_dec.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict   <= 1'b0;
            r_in_valid <= 1'b0;
            r_state    <= PARSE_RESET;
            r_left     <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_strict <= i_cfg_wr_data;
            end
            r_in_valid <= n_in_valid;
            r_state    <= n_state;
            r_left     <= n_left;
        end
    end

    // Hold payload registers without reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
    end

    `JSU_ASSERT_NEXT(a_run_continues, w_out_take && !o_res.run_last, o_res.valid,
        "result run broken before its last transaction")
    `JSU_ASSERT_SAME(a_code_matches_kind, o_res.valid,
        (o_res.kind == KIND_ERROR) == (o_res.error_code != ERR_NONE),
        "error code disagrees with result kind")
    `JSU_ASSERT_NEXT(a_final_mode_holds,
        w_move && !r_in.start_new && (r_state.mode == MODE_DONE || r_state.mode == MODE_ERR),
        $stable(r_state), "finished or failed parser changed without start_new")

endmodule

FILE: bench/jsu_unescape_checker.sv
// Result checker for the JSON string unescaper: mirrors the parser and compares each result.
`timescale 1ns / 100ps

module jsu_unescape_checker
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    jsu_in_if    i_in,
    jsu_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_items,
    output int   o_results,
    output int   o_closes,
    output int   o_errors
);

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } t_unesc_result;

    // Decoded results still owed by the block, oldest first
    t_unesc_result expected_q[$];

    // Mirror of the register and of the parser state
    logic        strict_quote;
    t_mode       mode;
    logic [2:0]  digits_seen;
    logic [15:0] code_point;
    int          step_count;

    function automatic void emit(input logic [7:0] data, input logic [1:0] kind,
                                 input logic [2:0] code);
        t_unesc_result r;
        r.data = data;
        r.kind = kind;
        r.code = code;
        r.last = 1'b0;
        expected_q.insert(expected_q.size(), r);
        step_count++;
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        mode = MODE_ERR;
        emit(8'h00, KIND_ERROR, code);
    endfunction

    // Value of a hex digit of either case, -1 for any other byte
    function automatic int nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    // UTF-8 bytes of one 16-bit code point, surrogates taken as they come
    function automatic void encode_code_point(input logic [15:0] cp);
        if (cp < 16'h0080) begin
            emit(cp[7:0], KIND_DATA, ERR_NONE);
        end else if (cp < 16'h0800) begin
            emit({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
            emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end else begin
            emit({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
            emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
            emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
    endfunction

    // Advance the mirrored parser by one input item and queue what it yields
    function automatic void unescape_step(input logic [7:0] b, input logic te,
                                          input logic sn);
        int d;
        step_count = 0;
        if (sn) begin
            mode        = MODE_NORMAL;
            digits_seen = '0;
            code_point  = '0;
        end
        if (te) begin
            case (mode)
                MODE_NORMAL: begin
                    mode = MODE_DONE;
                    emit(8'h00, KIND_CLOSE, ERR_NONE);
                end
                MODE_ESC: raise_error(ERR_END_ESC);
                MODE_HEX: raise_error(ERR_END_HEX);
                default: ;
            endcase
        end else begin
            case (mode)
                MODE_NORMAL: begin
                    if (b == CH_BSL) begin
                        mode = MODE_ESC;
                    end else if (b == CH_QUOTE) begin
                        if (strict_quote) begin
                            raise_error(ERR_BARE_QUOT);
                        end else begin
                            mode = MODE_DONE;
                            emit(8'h00, KIND_CLOSE, ERR_NONE);
                        end
                    end else begin
                        emit(b, KIND_DATA, ERR_NONE);
                    end
                end
                MODE_ESC: begin
                    mode = MODE_NORMAL;
                    case (b)
                        CH_QUOTE, CH_BSL, CH_SLASH: emit(b, KIND_DATA, ERR_NONE);
                        CH_B: emit(CH_BS, KIND_DATA, ERR_NONE);
                        CH_F: emit(CH_FF, KIND_DATA, ERR_NONE);
                        CH_N: emit(CH_LF, KIND_DATA, ERR_NONE);
                        CH_R: emit(CH_CR, KIND_DATA, ERR_NONE);
                        CH_T: emit(CH_TAB, KIND_DATA, ERR_NONE);
                        CH_U: begin
                            mode        = MODE_HEX;
                            digits_seen = '0;
                            code_point  = '0;
                        end
                        default: raise_error(ERR_BAD_ESC);
                    endcase
                end
                MODE_HEX: begin
                    d = nibble_of(b);
                    if (d < 0) begin
                        raise_error(ERR_BAD_HEX);
                    end else begin
                        code_point  = {code_point[11:0], d[3:0]};
                        digits_seen = digits_seen + 3'd1;
                        if (digits_seen == 3'd4) begin
                            encode_code_point(code_point);
                            mode        = MODE_NORMAL;
                            digits_seen = '0;
                            code_point  = '0;
                        end
                    end
                end
                // finished and error modes drop the item
                default: ;
            endcase
        end
        if (step_count > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // Track register writes, compare result transactions, predict input transactions
    always @(posedge i_clk) begin
        t_unesc_result want;
        if (!i_rst_n) begin
            expected_q.delete();
            strict_quote = 1'b0;
            mode         = MODE_NORMAL;
            digits_seen  = '0;
            code_point   = '0;
            o_fail_count = 0;
            o_items      = 0;
            o_results    = 0;
            o_closes     = 0;
            o_errors     = 0;
        end else begin
            if (i_cfg_wr_en) strict_quote = i_cfg_wr_data;

            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (i_res.kind == KIND_CLOSE) o_closes++;
                if (i_res.kind == KIND_ERROR) o_errors++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result data=%02h kind=%0d code=%0d last=%0b",
                             $time, i_res.out_byte, i_res.kind, i_res.error_code,
                             i_res.run_last);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.out_byte !== want.data || i_res.kind !== want.kind ||
                        i_res.error_code !== want.code || i_res.run_last !== want.last) begin
                        $display({"%0t: result mismatch, expected data=%02h kind=%0d ",
                                  "code=%0d last=%0b, actual data=%02h kind=%0d ",
                                  "code=%0d last=%0b"},
                                 $time, want.data, want.kind, want.code, want.last,
                                 i_res.out_byte, i_res.kind, i_res.error_code,
                                 i_res.run_last);
                        o_fail_count++;
                    end
                end
            end

            if (i_in.valid && i_in.ready) begin
                o_items++;
                unescape_step(i_in.in_byte, i_in.text_end, i_in.start_new);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: bench/tb_json_string_unescape.sv
// Testbench top for the JSON string unescaper: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_json_string_unescape;
    import jsu_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 6;
    // Longest quiet stretch in a good run is the receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 60;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B,
                                               CH_F, CH_N, CH_R, CH_T};
    localparam logic [15:0] BOUNDARY_CPS [6] = '{16'h0000, 16'h007F, 16'h0080,
                                                 16'h07FF, 16'h0800, 16'hFFFF};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    jsu_in_if  in_ch ();
    jsu_out_if res_ch ();

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int closes_seen;
    int errors_seen;

    int items_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int phases_run    = 0;
    bit new_string    = 1'b0;

    json_string_unescape dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_res         (res_ch)
    );

    jsu_unescape_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_items       (items_seen),
        .o_results     (results_seen),
        .o_closes      (closes_seen),
        .o_errors      (errors_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("json_string_unescape regression: fail");
                $finish;
            end
        end
    end

    // Offer one item after an optional random gap; return at the negedge after acceptance
    task automatic send_item(input logic [7:0] b, input logic te, input logic sn);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.text_end  <= te;
        in_ch.start_new <= sn | new_string;
        new_string = 1'b0;
        items_sent++;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is out and the pipeline is empty
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_quote_mode(input logic strict);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= strict;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + n;
        return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + n - 8'd10;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] b);
        foreach (ESC_LETTERS[i]) if (ESC_LETTERS[i] == b) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_BSL || b == CH_QUOTE);
        return b;
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(4))
            0: return 16'($urandom_range(16'h007F, 16'h0000));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2: return 16'($urandom_range(16'hFFFF, 16'h0800));
            3: return BOUNDARY_CPS[$urandom_range(5)];
            default: return 16'($urandom_range(16'hDFFF, 16'hD800));
        endcase
    endfunction

    // Backslash, u, then the leading digits of the code point
    task automatic send_u_escape(input logic [15:0] cp, input int ndigits);
        int i;
        send_item(CH_BSL, 1'b0, 1'b0);
        send_item(CH_U, 1'b0, 1'b0);
        for (i = 0; i < ndigits; i++) send_item(hex_char(cp[15 - 4*i -: 4]), 1'b0, 1'b0);
    endtask

    task automatic send_token();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: send_item(plain_byte(), 1'b0, 1'b0);
            5, 6: begin
                send_item(CH_BSL, 1'b0, 1'b0);
                send_item(ESC_LETTERS[$urandom_range(7)], 1'b0, 1'b0);
            end
            default: send_u_escape(pick_code_point(), 4);
        endcase
    endtask

    // A whole string body, closed by text end or by a bare quote
    task automatic send_well_formed();
        int n;
        int i;
        new_string = 1'b1;
        n = $urandom_range(6, 0);
        for (i = 0; i < n; i++) send_token();
        if ($urandom_range(1)) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        else send_item(CH_QUOTE, 1'b0, 1'b0);
    endtask

    // A string that goes wrong inside an escape, then a few dropped items
    task automatic send_broken();
        logic [7:0] b;
        new_string = 1'b1;
        repeat ($urandom_range(2)) send_token();
        case ($urandom_range(3))
            0: begin
                do b = 8'($urandom_range(255)); while (is_escape_letter(b) || b == CH_U);
                send_item(CH_BSL, 1'b0, 1'b0);
                send_item(b, 1'b0, 1'b0);
            end
            1: begin
                do b = 8'($urandom_range(255)); while (is_hex_char(b));
                send_u_escape(pick_code_point(), $urandom_range(3));
                send_item(b, 1'b0, 1'b0);
            end
            2: begin
                send_item(CH_BSL, 1'b0, 1'b0);
                send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            end
            default: begin
                send_u_escape(pick_code_point(), $urandom_range(3));
                send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            end
        endcase
        repeat ($urandom_range(2)) send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 1))
            send_item(8'($urandom_range(255)), $urandom_range(3) == 0, 1'($urandom_range(1)));
    endtask

    task automatic run_phase(input logic strict, input int send_pct, input int recv_pct,
                             input bit hold);
        int target;
        int pick;
        set_quote_mode(strict);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        if (hold) hold_left = HOLD_CYCLES;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) send_well_formed();
            else if (pick < 90) send_broken();
            else send_noise();
        end
        phases_run++;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.text_end  = 1'b0;
        in_ch.start_new = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, lenient quote: byte extremes, a letter escape, 3-byte code point,
        // quote close, then an end that is dropped
        set_quote_mode(1'b0);
        new_string = 1'b1;
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(CH_BSL, 1'b0, 1'b0);
        send_item(CH_T, 1'b0, 1'b0);
        send_item(CH_BSL, 1'b0, 1'b0);
        send_item(CH_U, 1'b0, 1'b0);
        send_item("F", 1'b0, 1'b0);
        send_item("f", 1'b0, 1'b0);
        send_item("F", 1'b0, 1'b0);
        send_item("f", 1'b0, 1'b0);
        send_item(CH_QUOTE, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        // Unknown escape, then a byte dropped in error mode
        send_item(CH_BSL, 1'b0, 1'b1);
        send_item("q", 1'b0, 1'b0);
        send_item("a", 1'b0, 1'b0);
        // Bad hex digit
        send_item(CH_BSL, 1'b0, 1'b1);
        send_item(CH_U, 1'b0, 1'b0);
        send_item("1", 1'b0, 1'b0);
        send_item("G", 1'b0, 1'b0);
        // End right after a backslash, end inside a u-escape, clean end
        send_item(CH_BSL, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(CH_BSL, 1'b0, 1'b1);
        send_item(CH_U, 1'b0, 1'b0);
        send_item("a", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // Bare quote under strict mode
        set_quote_mode(1'b1);
        send_item(CH_QUOTE, 1'b0, 1'b1);

        // Random phases: no idling, idle sender, stalling receiver, both, long hold-off
        run_phase(1'b0, 0, 0, 1'b0);
        run_phase(1'b1, 57, 0, 1'b0);
        run_phase(1'b0, 0, 57, 1'b0);
        run_phase(1'b1, 17, 17, 1'b0);
        run_phase(1'b0, 0, 0, 1'b1);

        wait_idle();
        $display("Covered %0d items and %0d results (%0d closes, %0d errors) in %0d phases,",
                 items_seen, results_seen, closes_seen, errors_seen, phases_run);
        $display("strict quote off and on, idle sender and receiver, and a long output hold-off.");
        if (fail_count == 0) begin
            $display("json_string_unescape regression: pass");
        end else begin
            $display("json_string_unescape regression: fail");
        end
        $finish;
    end

endmodule
